/* sv/llvt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llvt_pkg: shared types and constants of the lane leader vehicle table
// Command codes, register map, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package llvt_pkg;

  localparam int unsigned MAX_VEHICLES_DEF = 32;

  localparam int unsigned ID_W  = 16;
  localparam int unsigned POS_W = 24;

  // Configuration port: one register on a 32-bit data bus, byte addressed.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_LANE_LENGTH = 1'b0;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_UPDATE = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  typedef struct packed {
    cmd_t             command;
    logic [ID_W-1:0]  vehicle_id;
    logic [POS_W-1:0] offset;
    logic [POS_W-1:0] awareness;
  } in_item_t;

  typedef struct packed {
    logic            leader_found;
    logic [ID_W-1:0] leader_id;
    logic            table_full;
  } out_item_t;

  // One table entry as it is kept in the slot memory.
  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  vehicle;
    logic [POS_W-1:0] position;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* sv/lane_leader_vehicle_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted command is scanned over every slot in turn, passes the drain and final
//   states, and its result is registered. A new command is taken only once the block
//   is idle again. The slot memory is read once per slot by the shared compare unit.
// Reset: rst_n is synchronous; after it the block runs a clearing pass over the slot
//   memory with busy high. Configuration writes are taken throughout.
// The receiver cannot stall: out_strobe marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
// lane_leader_vehicle_table
// Table of vehicles on one lane with update, remove and leader query
// commands, served by a slot-by-slot scan through one compare unit.
// ----------------------------------------------------------------------------
module lane_leader_vehicle_table
  import llvt_pkg::*;
#(
  parameter int unsigned MAX_VEHICLES = MAX_VEHICLES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_item,
  // Result channel
  output logic                       out_strobe,
  output out_item_t                  out_item,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int unsigned IDX_W = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VEHICLES - 1);

  // --------------------------------------------------------------------------
  // Configuration register. The only register is the lane length; a write
  // transfer completes when psel, penable, pwrite and pready are all high.
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] lane_length_r;
  logic             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[CFG_ADDR_W-1:2] == REG_LANE_LENGTH);
  assign prdata  = cfg_sel ? CFG_DATA_W'(lane_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_length_r <= '0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      lane_length_r <= pwdata[POS_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Slot memory. Each word holds the valid flag, vehicle id and offset of one
  // slot. It has one write port and one registered read port. The sequencer
  // reads slot addr_r during the scan, and the entry comes back in the next cycle
  // in rd_slot_r, tagged with its index in rd_idx_r.
  // --------------------------------------------------------------------------
  slot_t            mem_q [MAX_VEHICLES];
  slot_t            rd_slot_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_v_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and command registers
  // --------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  in_item_t         item_r;
  logic             accept;
  logic             rd_en;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_slot_r <= mem_q[addr_r];
      rd_idx_r  <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      rd_v_r  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (addr_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:  if (start)              state_nxt = ST_SCAN;
      ST_SCAN:  if (addr_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared compare unit. One returned entry is examined per cycle. For update
  // and remove it tracks the first slot that already holds the vehicle and
  // the first free slot. For a query it keeps the best gap so far, which
  // starts at the lane length so that a gap must lie strictly below it. On an
  // equal gap the lower vehicle id takes over.
  // --------------------------------------------------------------------------
  logic             match_found_r, match_found_nxt;
  logic [IDX_W-1:0] match_slot_r, match_slot_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_slot_r, free_slot_nxt;
  logic [POS_W-1:0] best_r, best_nxt;
  logic             lead_found_r, lead_found_nxt;
  logic [ID_W-1:0]  lead_id_r, lead_id_nxt;

  logic             hit;
  logic             eligible;
  logic [POS_W-1:0] gap;

  always_comb begin
    hit      = rd_slot_r.valid && (rd_slot_r.vehicle == item_r.vehicle_id);
    eligible = rd_slot_r.valid && (rd_slot_r.vehicle != item_r.vehicle_id)
               && (rd_slot_r.position >= item_r.offset)
               && (rd_slot_r.position < item_r.awareness);
    gap      = rd_slot_r.position - item_r.offset;

    match_found_nxt = match_found_r;
    match_slot_nxt  = match_slot_r;
    free_found_nxt  = free_found_r;
    free_slot_nxt   = free_slot_r;
    best_nxt        = best_r;
    lead_found_nxt  = lead_found_r;
    lead_id_nxt     = lead_id_r;

    if (accept) begin
      match_found_nxt = 1'b0;
      free_found_nxt  = 1'b0;
      best_nxt        = lane_length_r;
      lead_found_nxt  = 1'b0;
      lead_id_nxt     = '0;
    end else if (rd_v_r) begin
      if (hit && !match_found_r) begin
        match_found_nxt = 1'b1;
        match_slot_nxt  = rd_idx_r;
      end
      if (!rd_slot_r.valid && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_slot_nxt  = rd_idx_r;
      end
      if (eligible) begin
        priority if (gap < best_r) begin
          best_nxt       = gap;
          lead_found_nxt = 1'b1;
          lead_id_nxt    = rd_slot_r.vehicle;
        end else if (lead_found_r && (gap == best_r)
                     && (rd_slot_r.vehicle < lead_id_r)) begin
          lead_id_nxt = rd_slot_r.vehicle;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      lead_found_r  <= 1'b0;
    end else begin
      match_found_r <= match_found_nxt;
      free_found_r  <= free_found_nxt;
      lead_found_r  <= lead_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_slot_r <= match_slot_nxt;
    free_slot_r  <= free_slot_nxt;
    best_r       <= best_nxt;
    lead_id_r    <= lead_id_nxt;
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs. The clearing pass writes an empty word to every slot.
  // In the final state an update writes its slot (the known one, else the
  // first free one, else it reports a full table) and a remove clears the
  // slot of the known vehicle. The result is registered and strobed for one
  // cycle; commands other than query and update report all zeros.
  // --------------------------------------------------------------------------
  logic      out_strobe_r, out_strobe_nxt;
  out_item_t out_item_r, out_item_nxt;

  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = '0;
    rd_en          = 1'b0;
    addr_nxt       = addr_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          addr_nxt = '0;
        end
      end
      ST_SCAN: begin
        rd_en    = 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        out_strobe_nxt = 1'b1;
        out_item_nxt   = '0;
        mem_wdata      = '{valid: 1'b1, vehicle: item_r.vehicle_id,
                           position: item_r.offset};
        unique case (item_r.command)
          CMD_UPDATE: begin
            if (match_found_r) begin
              mem_we    = 1'b1;
              mem_waddr = match_slot_r;
            end else if (free_found_r) begin
              mem_we    = 1'b1;
              mem_waddr = free_slot_r;
            end else begin
              out_item_nxt.table_full = 1'b1;
            end
          end
          CMD_REMOVE: begin
            mem_we          = match_found_r;
            mem_waddr       = match_slot_r;
            mem_wdata.valid = 1'b0;
          end
          CMD_QUERY: begin
            out_item_nxt.leader_found = lead_found_r;
            out_item_nxt.leader_id    = lead_id_r;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTH
  // An accepted command always enters the scan.
  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN) && (addr_r == '0))
    else $error("accepted command did not start a scan");

  // Exactly one result follows the final state.
  a_done_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_strobe)
    else $error("final state produced no result");

  // A result is only strobed right after the final state.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_DONE))
    else $error("result strobed outside the final state");

  // A full table is only reported for an update.
  a_full_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.table_full |-> (item_r.command == CMD_UPDATE))
    else $error("table_full reported for a non-update command");

  // A leader is only reported for a query.
  a_found_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.leader_found |-> (item_r.command == CMD_QUERY))
    else $error("leader reported for a non-query command");
`endif

endmodule
`default_nettype wire
